// ===== hdl/ucd_pkg.sv =====
// ucd_pkg: shared widths, lead byte prefixes and the result flag struct
// for the utf8 character decoder; no dependencies
package ucd_pkg;

   localparam int BYTE_WIDTH             = 8;
   localparam int CODE_WIDTH             = 22;
   localparam int LEN_WIDTH              = 3;
   localparam int REM_WIDTH              = 2;
   localparam int POSITION_WIDTH_DEFAULT = 16;

   // lead byte prefixes and the continuation marker
   localparam logic [4:0] LEAD4_TAG = 5'b11110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [BYTE_WIDTH-1:0] LEAD4_PREFIX = 8'hF0;
   localparam logic [BYTE_WIDTH-1:0] LEAD3_PREFIX = 8'hE0;
   localparam logic [BYTE_WIDTH-1:0] LEAD2_PREFIX = 8'hC0;
   localparam logic [BYTE_WIDTH-1:0] CONT_PREFIX  = 8'h80;

   localparam logic [LEN_WIDTH-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_WIDTH-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_WIDTH-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_WIDTH-1:0] LEN_FOUR  = 3'd4;

   localparam logic MODE_UTF8   = 1'b0;
   localparam logic MODE_BINARY = 1'b1;

   typedef struct packed {
      logic [LEN_WIDTH-1:0] char_bytes;
      logic                 truncated;
      logic                 final_result;
   } ucd_flags_type;

endpackage

// ===== hdl/ucd_if.sv =====
// ucd_if: valid/ready channels for the utf8 character decoder
// (byte requests, character responses, mode register writes); uses ucd_pkg
interface ucd_req_if;
   logic                             valid;
   logic                             ready;
   logic [ucd_pkg::BYTE_WIDTH-1:0]   in_byte;
   logic                             end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface ucd_rsp_if #(
   parameter int POSITION_WIDTH = ucd_pkg::POSITION_WIDTH_DEFAULT
);
   logic                             valid;
   logic                             ready;
   logic [ucd_pkg::CODE_WIDTH-1:0]   code_point;
   logic [ucd_pkg::LEN_WIDTH-1:0]    char_bytes;
   logic [POSITION_WIDTH-1:0]        char_number;
   logic [POSITION_WIDTH-1:0]        lead_offset;
   logic                             truncated;
   logic                             final_result;

   modport source (output valid, output code_point, output char_bytes, output char_number,
                   output lead_offset, output truncated, output final_result, input ready);
   modport sink   (input valid, input code_point, input char_bytes, input char_number,
                   input lead_offset, input truncated, input final_result, output ready);
endinterface

interface ucd_csr_if;
   logic valid;
   logic ready;
   logic encoding_mode;

   modport source (output valid, output encoding_mode, input ready);
   modport sink   (input valid, input encoding_mode, output ready);
endinterface

// ===== hdl/utf8_char_decoder.sv =====
// utf8_char_decoder: top level of the streaming utf8 character decoder
// depends on ucd_pkg, ucd_if, ucd_core and ucd_out_reg
//
// usage
//  req_bus: one string byte per beat, end_of_string on the last byte
//  rsp_bus: one beat per finished character, or one truncation beat when
//           the string ends inside a multi-byte sequence (code_point 0)
//  csr_bus: writes encoding_mode (0 utf8, 1 one byte per character); always
//           ready, write only while no byte is in flight
//  a byte is decoded in the cycle it is accepted and its result, if any, is
//  shown on rsp_bus from the next cycle
//  throughput one byte per cycle while results are taken, set by the single
//  result register; lead and middle bytes not ending a string never use it
//  when the receiver stalls, a held result blocks every further byte:
//  req_bus.ready is low while the register holds a beat that is not being
//  taken, and high while it is empty or being taken
//  reset (synchronous) clears the sequence state, positions, the result
//  register and selects utf8 mode
//  byte offsets and character indices saturate at 2**POSITION_WIDTH-1
module utf8_char_decoder #(
   parameter int POSITION_WIDTH = ucd_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ucd_req_if.sink   req_bus,
   ucd_rsp_if.source rsp_bus,
   ucd_csr_if.sink   csr_bus
);

   logic                           mode_ff;
   logic                           accept;
   logic                           emit;
   logic                           free;
   logic [ucd_pkg::CODE_WIDTH-1:0] dec_code;
   logic [POSITION_WIDTH-1:0]      dec_index;
   logic [POSITION_WIDTH-1:0]      dec_offset;
   ucd_pkg::ucd_flags_type         dec_flags;
   ucd_pkg::ucd_flags_type         out_flags;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = free;
   assign accept        = req_bus.valid && free;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ucd_pkg::MODE_UTF8;
      end else if (csr_bus.valid) begin
         mode_ff <= csr_bus.encoding_mode;
      end
   end

   ucd_core #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_bus.in_byte),
      .end_of_string (req_bus.end_of_string),
      .encoding_mode (mode_ff),
      .emit          (emit),
      .code_point    (dec_code),
      .char_number   (dec_index),
      .lead_offset   (dec_offset),
      .flags         (dec_flags)
   );

   ucd_out_reg #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (accept && emit),
      .code_point  (dec_code),
      .char_number (dec_index),
      .lead_offset (dec_offset),
      .flags       (dec_flags),
      .drain       (rsp_bus.ready),
      .free        (free),
      .valid_ff    (rsp_bus.valid),
      .code_ff     (rsp_bus.code_point),
      .index_ff    (rsp_bus.char_number),
      .offset_ff   (rsp_bus.lead_offset),
      .flags_ff    (out_flags)
   );

   assign rsp_bus.char_bytes   = out_flags.char_bytes;
   assign rsp_bus.truncated    = out_flags.truncated;
   assign rsp_bus.final_result = out_flags.final_result;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && req_bus.ready)
      else $error("result register not empty after reset");
   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_bus.valid |=> mode_ff == $past(csr_bus.encoding_mode))
      else $error("mode register write lost");
`endif

endmodule

// ===== hdl/ucd_core.sv =====
// ucd_core: sequence state and the single-pass byte decode for the utf8
// character decoder; uses ucd_pkg
module ucd_core #(
   parameter int POSITION_WIDTH = ucd_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [ucd_pkg::BYTE_WIDTH-1:0]   in_byte,
   input  logic                             end_of_string,
   input  logic                             encoding_mode,
   output logic                             emit,
   output logic [ucd_pkg::CODE_WIDTH-1:0]   code_point,
   output logic [POSITION_WIDTH-1:0]        char_number,
   output logic [POSITION_WIDTH-1:0]        lead_offset,
   output ucd_pkg::ucd_flags_type           flags
);

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

   logic [ucd_pkg::REM_WIDTH-1:0]  rem_ff,   rem_in;
   logic [ucd_pkg::LEN_WIDTH-1:0]  len_ff,   len_in;
   logic [ucd_pkg::CODE_WIDTH-1:0] code_ff,  code_in;
   logic [POSITION_WIDTH-1:0]      start_ff, start_in;
   logic [POSITION_WIDTH-1:0]      pos_ff,   pos_in;
   logic [POSITION_WIDTH-1:0]      cnt_ff,   cnt_in;

   logic [ucd_pkg::CODE_WIDTH-1:0] code_shift;
   logic [ucd_pkg::REM_WIDTH-1:0]  rem_dec;
   logic [ucd_pkg::LEN_WIDTH-1:0]  lead_len;
   logic [ucd_pkg::BYTE_WIDTH-1:0] lead_bits;
   logic [POSITION_WIDTH-1:0]      pos_inc, cnt_inc;

   assign code_shift = {code_ff[ucd_pkg::CODE_WIDTH-7:0], 6'd0}
                     + {14'd0, in_byte ^ ucd_pkg::CONT_PREFIX};
   assign rem_dec    = rem_ff - 2'd1;
   assign pos_inc    = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign cnt_inc    = (cnt_ff == POS_MAX) ? cnt_ff : cnt_ff + 1'b1;

   // classify a byte arriving with no sequence open
   always_comb begin
      lead_len  = ucd_pkg::LEN_ONE;
      lead_bits = in_byte;
      if (encoding_mode == ucd_pkg::MODE_UTF8) begin
         priority if (in_byte[7:3] == ucd_pkg::LEAD4_TAG) begin
            lead_len  = ucd_pkg::LEN_FOUR;
            lead_bits = in_byte ^ ucd_pkg::LEAD4_PREFIX;
         end else if (in_byte[7:4] == ucd_pkg::LEAD3_TAG) begin
            lead_len  = ucd_pkg::LEN_THREE;
            lead_bits = in_byte ^ ucd_pkg::LEAD3_PREFIX;
         end else if (in_byte[7:5] == ucd_pkg::LEAD2_TAG) begin
            lead_len  = ucd_pkg::LEN_TWO;
            lead_bits = in_byte ^ ucd_pkg::LEAD2_PREFIX;
         end else begin
            lead_len  = ucd_pkg::LEN_ONE;
            lead_bits = in_byte;
         end
      end
   end

   always_comb begin
      rem_in             = rem_ff;
      len_in             = len_ff;
      code_in            = code_ff;
      start_in           = start_ff;
      cnt_in             = cnt_ff;
      pos_in             = pos_inc;
      emit               = 1'b0;
      code_point         = '0;
      char_number        = cnt_ff;
      lead_offset        = start_ff;
      flags.char_bytes   = len_ff;
      flags.truncated    = 1'b0;
      flags.final_result = end_of_string;
      if (rem_ff != '0) begin
         // continuation beat: the open sequence completes whatever the mode
         code_in = code_shift;
         rem_in  = rem_dec;
         if (rem_dec == '0) begin
            emit       = 1'b1;
            code_point = code_shift;
            cnt_in     = cnt_inc;
         end else if (end_of_string) begin
            emit            = 1'b1;
            flags.truncated = 1'b1;
         end
      end else if (lead_len == ucd_pkg::LEN_ONE) begin
         emit             = 1'b1;
         code_point       = {14'd0, in_byte};
         lead_offset      = pos_ff;
         flags.char_bytes = ucd_pkg::LEN_ONE;
         cnt_in           = cnt_inc;
      end else begin
         rem_in           = ucd_pkg::REM_WIDTH'(lead_len - 3'd1);
         len_in           = lead_len;
         code_in          = {14'd0, lead_bits};
         start_in         = pos_ff;
         lead_offset      = pos_ff;
         flags.char_bytes = lead_len;
         if (end_of_string) begin
            emit            = 1'b1;
            flags.truncated = 1'b1;
         end
      end
      if (end_of_string) begin
         rem_in   = '0;
         len_in   = '0;
         code_in  = '0;
         start_in = '0;
         pos_in   = '0;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         len_ff   <= '0;
         code_ff  <= '0;
         start_ff <= '0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else if (accept) begin
         rem_ff   <= rem_in;
         len_ff   <= len_in;
         code_ff  <= code_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_rem_below_len: assert property (@(posedge clock) disable iff (reset)
      rem_ff != '0 |-> (len_ff > {1'b0, rem_ff}) && (len_ff <= ucd_pkg::LEN_FOUR))
      else $error("open sequence count exceeds its length");
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_string |=> rem_ff == '0 && pos_ff == '0 && cnt_ff == '0)
      else $error("state not cleared after final beat");
   a_chars_le_bytes: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= pos_ff)
      else $error("character count ahead of byte position");
   a_trunc_is_final: assert property (@(posedge clock) disable iff (reset)
      accept && emit && flags.truncated |-> flags.final_result && code_point == '0)
      else $error("truncation result not final");
`endif

endmodule

// ===== hdl/ucd_out_reg.sv =====
// ucd_out_reg: result register of the utf8 character decoder, holding one
// character beat until the receiver takes it; uses ucd_pkg
module ucd_out_reg #(
   parameter int POSITION_WIDTH = ucd_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic [ucd_pkg::CODE_WIDTH-1:0]   code_point,
   input  logic [POSITION_WIDTH-1:0]        char_number,
   input  logic [POSITION_WIDTH-1:0]        lead_offset,
   input  ucd_pkg::ucd_flags_type           flags,
   input  logic                             drain,
   output logic                             free,
   output logic                             valid_ff,
   output logic [ucd_pkg::CODE_WIDTH-1:0]   code_ff,
   output logic [POSITION_WIDTH-1:0]        index_ff,
   output logic [POSITION_WIDTH-1:0]        offset_ff,
   output ucd_pkg::ucd_flags_type           flags_ff
);

   logic valid_in;

   // room for a new beat when empty or being emptied this cycle
   assign free     = !valid_ff || drain;
   assign valid_in = load || (valid_ff && !drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff   <= code_point;
         index_ff  <= char_number;
         offset_ff <= lead_offset;
         flags_ff  <= flags;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result register loaded while holding an untaken beat");
`endif

endmodule
